FILE: rtl/core/dnsqe_pkg.sv
package dnsqe_pkg;

  localparam int unsigned MaxLabelBytes = 63;
  localparam int unsigned MaxNameOctets = 255;
  localparam int unsigned LblW          = 6;
  localparam int unsigned CntW          = 9;
  localparam int unsigned PcW           = 5;
  localparam int unsigned CfgW          = 16;

  localparam logic [CntW-1:0] CntSat     = {CntW{1'b1}};
  localparam logic [7:0]      DotChar    = 8'd46;
  localparam logic [7:0]      QtypeAaaa  = 8'h1c;
  localparam logic [7:0]      QtypeA     = 8'h01;
  localparam logic [CfgW-1:0] CfgReset   = 16'd4096;
  localparam logic [CfgW-1:0] MinMessage = 16'd18;
  localparam logic [9:0]      FixedBytes = 10'd17;

  localparam logic [1:0] CmdBegin  = 2'd0;
  localparam logic [1:0] CmdChar   = 2'd1;
  localparam logic [1:0] CmdFinish = 2'd2;

  localparam logic [1:0] ErrNone   = 2'd0;
  localparam logic [1:0] ErrLabel  = 2'd1;
  localparam logic [1:0] ErrName   = 2'd2;
  localparam logic [1:0] ErrBuffer = 2'd3;

  localparam logic [PcW-1:0] StepHeader    = 5'd0;
  localparam logic [PcW-1:0] StepLabelLen  = 5'd12;
  localparam logic [PcW-1:0] StepLabelByte = 5'd13;
  localparam logic [PcW-1:0] StepFinEmpty  = 5'd14;
  localparam logic [PcW-1:0] StepFinish    = 5'd15;

  typedef enum logic [1:0] {
    SrcConst,
    SrcLabelLen,
    SrcStore,
    SrcQtype
  } src_e;

  typedef enum logic [1:0] {
    OpNext,
    OpEnd,
    OpLenBranch,
    OpLabelLoop
  } op_e;

  typedef struct packed {
    src_e       src;
    logic [7:0] konst;
    op_e        op;
    logic       msg_len;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    ctrl_t c;
    c = '{src: SrcConst, konst: 8'h00, op: OpNext, msg_len: 1'b0};
    unique case (pc)
      5'd0, 5'd1, 5'd3, 5'd4, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10: c.op = OpNext;
      5'd2, 5'd5: c.konst = 8'h01;
      5'd11: c.op = OpEnd;
      StepLabelLen: begin
        c.src = SrcLabelLen;
        c.op  = OpLenBranch;
      end
      StepLabelByte: begin
        c.src = SrcStore;
        c.op  = OpLabelLoop;
      end
      StepFinEmpty, 5'd15, 5'd16, 5'd18: c.op = OpNext;
      5'd17: c.src = SrcQtype;
      5'd19: begin
        c.konst   = 8'h01;
        c.op      = OpEnd;
        c.msg_len = 1'b1;
      end
      default: c.op = OpEnd;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/dns_query_message_encoder.sv
// DNS query message encoder.
// Input beats on s_axis: tuser selects begin, host name character or finish.
// Output beats on m_axis carry the message one byte per beat; tlast marks the
// final byte caused by an input beat, and the finish beat's last byte carries
// the total message length. Errors ride on every output byte; drop the run.
// cfg_* writes the message buffer limit: the user writes it only while the block is idle (unenforced).
// A begin gives 12 header bytes, a dot or last character gives 1 + label
// length bytes, a finish gives 5 or 6 bytes; other characters give none.
// A taken beat sets the sequencer busy, which then loads its first byte into the output register.
// One byte leaves per cycle while m_axis_tready is high, set by the microcode
// step counter; the next input beat can be taken once the last byte of the
// previous beat is in the output register.
// Label bytes come from a 63-entry store with registered read, prefetched
// one step ahead.
// Reset clears the counters, error and sequencer; the limit returns to 4096.
// The label store is not cleared. When m_axis_tready is low with a beat valid,
// the output beat holds and the sequencer waits.
module dns_query_message_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // want_ipv6, name_char[8:1], zeros
  input  logic [1:0]  s_axis_tuser,   // command
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_byte, error_code[9:8], message_length[18:10], zeros
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [dnsqe_pkg::CfgW-1:0] max_q;
  logic [dnsqe_pkg::LblW-1:0] label_len_q, label_len_d;
  logic [dnsqe_pkg::LblW-1:0] flush_len_q, flush_len_d;
  logic [dnsqe_pkg::CntW-1:0] noc_q, noc_d;
  logic [dnsqe_pkg::CntW-1:0] host_q, host_d;
  logic                       ipv6_q, ipv6_d;
  logic [1:0]                 err_q, err_d;
  logic                       any_q, any_d;

  logic                       busy_q, busy_d;
  logic [dnsqe_pkg::PcW-1:0]  pc_q, pc_d;
  logic [dnsqe_pkg::LblW-1:0] idx_q, idx_d;

  logic       out_valid_q;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic [1:0] out_err_q;
  logic [8:0] out_len_q, out_len_d;

  logic [1:0] cmd;
  logic       want_ipv6;
  logic [7:0] name_char;
  logic       accept;
  logic       load;
  logic       is_dot;
  logic       store_full;
  logic       store_we;
  logic       flush;
  logic [dnsqe_pkg::LblW-1:0] len_after;
  logic [dnsqe_pkg::CntW-1:0] host_inc;
  logic [16:0]                need;
  logic [9:0]                 noc_sum;
  logic [9:0]                 msg_sum;
  logic [7:0]                 rdata;
  dnsqe_pkg::ctrl_t           ctrl;
  logic                       step_last;

  assign cmd         = s_axis_tuser;
  assign want_ipv6   = s_axis_tdata[0];
  assign name_char   = s_axis_tdata[8:1];
  assign s_axis_tready = !busy_q;
  assign accept      = s_axis_tvalid && !busy_q;
  assign load        = busy_q && (!out_valid_q || m_axis_tready);
  assign cfg_ready_o = 1'b1;

  assign is_dot     = (name_char == dnsqe_pkg::DotChar);
  assign store_full = (label_len_q == dnsqe_pkg::LblW'(dnsqe_pkg::MaxLabelBytes));
  assign store_we   = accept && (cmd == dnsqe_pkg::CmdChar) && !is_dot && !store_full;
  assign len_after  = store_full ? label_len_q : label_len_q + 1'b1;
  assign flush      = is_dot || s_axis_tlast;
  assign host_inc   = (host_q == dnsqe_pkg::CntSat) ? host_q : host_q + 1'b1;
  assign need       = 17'(host_inc) + 17'd18;

  always_comb begin
    label_len_d = label_len_q;
    flush_len_d = flush_len_q;
    noc_d       = noc_q;
    host_d      = host_q;
    ipv6_d      = ipv6_q;
    err_d       = err_q;
    any_d       = any_q;
    noc_sum     = '0;
    if (accept) begin
      unique case (cmd)
        dnsqe_pkg::CmdBegin: begin
          label_len_d = '0;
          noc_d       = '0;
          host_d      = '0;
          any_d       = 1'b0;
          ipv6_d      = want_ipv6;
          err_d       = (max_q < dnsqe_pkg::MinMessage) ? dnsqe_pkg::ErrBuffer
                                                        : dnsqe_pkg::ErrNone;
        end
        dnsqe_pkg::CmdChar: begin
          any_d  = 1'b1;
          host_d = host_inc;
          if ((err_d == dnsqe_pkg::ErrNone) && (need > {1'b0, max_q})) begin
            err_d = dnsqe_pkg::ErrBuffer;
          end
          if (is_dot) begin
            flush_len_d = label_len_q;
          end else begin
            if ((err_d == dnsqe_pkg::ErrNone) && store_full) begin
              err_d = dnsqe_pkg::ErrLabel;
            end
            flush_len_d = len_after;
            label_len_d = len_after;
          end
          if (flush) begin
            noc_sum     = {1'b0, noc_q} + 10'(flush_len_d) + 10'd1;
            noc_d       = noc_sum[9] ? dnsqe_pkg::CntSat : noc_sum[8:0];
            label_len_d = '0;
            if ((err_d == dnsqe_pkg::ErrNone) &&
                (noc_d > dnsqe_pkg::CntW'(dnsqe_pkg::MaxNameOctets))) begin
              err_d = dnsqe_pkg::ErrName;
            end
          end
        end
        dnsqe_pkg::CmdFinish: begin
          label_len_d = '0;
          if (!any_q) begin
            noc_sum = {1'b0, noc_q} + 10'd1;
            noc_d   = noc_sum[9] ? dnsqe_pkg::CntSat : noc_sum[8:0];
            if ((err_d == dnsqe_pkg::ErrNone) &&
                (noc_d > dnsqe_pkg::CntW'(dnsqe_pkg::MaxNameOctets))) begin
              err_d = dnsqe_pkg::ErrName;
            end
          end
        end
        default: begin
          err_d = err_q;
        end
      endcase
    end
  end

  assign ctrl    = dnsqe_pkg::ucode(pc_q);
  assign msg_sum = {1'b0, noc_q} + dnsqe_pkg::FixedBytes;

  always_comb begin
    step_last = 1'b0;
    unique case (ctrl.op)
      dnsqe_pkg::OpNext:      step_last = 1'b0;
      dnsqe_pkg::OpEnd:       step_last = 1'b1;
      dnsqe_pkg::OpLenBranch: step_last = (flush_len_q == '0);
      dnsqe_pkg::OpLabelLoop: step_last = (idx_q == flush_len_q - 1'b1);
      default:                step_last = 1'b1;
    endcase
  end

  always_comb begin
    unique case (ctrl.src)
      dnsqe_pkg::SrcConst:    out_byte_d = ctrl.konst;
      dnsqe_pkg::SrcLabelLen: out_byte_d = 8'(flush_len_q);
      dnsqe_pkg::SrcStore:    out_byte_d = rdata;
      dnsqe_pkg::SrcQtype:    out_byte_d = ipv6_q ? dnsqe_pkg::QtypeAaaa : dnsqe_pkg::QtypeA;
      default:                out_byte_d = ctrl.konst;
    endcase
    out_last_d = step_last;
    out_len_d  = ctrl.msg_len ? (msg_sum[9] ? 9'h1ff : msg_sum[8:0]) : 9'd0;
  end

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    idx_d  = idx_q;
    if (accept) begin
      unique case (cmd)
        dnsqe_pkg::CmdBegin: begin
          busy_d = 1'b1;
          pc_d   = dnsqe_pkg::StepHeader;
        end
        dnsqe_pkg::CmdChar: begin
          busy_d = flush;
          pc_d   = dnsqe_pkg::StepLabelLen;
          idx_d  = '0;
        end
        dnsqe_pkg::CmdFinish: begin
          busy_d = 1'b1;
          pc_d   = any_q ? dnsqe_pkg::StepFinish : dnsqe_pkg::StepFinEmpty;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end else if (load) begin
      if (step_last) begin
        busy_d = 1'b0;
      end else if (ctrl.op == dnsqe_pkg::OpLabelLoop) begin
        idx_d = idx_q + 1'b1;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  dnsqe_ram #(
    .Width(8),
    .Depth(dnsqe_pkg::MaxLabelBytes)
  ) u_label_store (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(label_len_q),
    .wdata_i(name_char),
    .raddr_i(idx_d),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= dnsqe_pkg::CfgReset;
      label_len_q <= '0;
      flush_len_q <= '0;
      noc_q       <= '0;
      host_q      <= '0;
      ipv6_q      <= 1'b0;
      err_q       <= dnsqe_pkg::ErrNone;
      any_q       <= 1'b0;
      busy_q      <= 1'b0;
      pc_q        <= dnsqe_pkg::StepHeader;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        max_q <= cfg_data_i;
      end
      label_len_q <= label_len_d;
      flush_len_q <= flush_len_d;
      noc_q       <= noc_d;
      host_q      <= host_d;
      ipv6_q      <= ipv6_d;
      err_q       <= err_d;
      any_q       <= any_d;
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      idx_q       <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= out_byte_d;
      out_last_q <= out_last_d;
      out_err_q  <= err_q;
      out_len_q  <= out_len_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {5'd0, out_len_q, out_err_q, out_byte_q};

endmodule

FILE: rtl/core/dnsqe_ram.sv
module dnsqe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 63,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
